/* hdl/lbspe_pkg.sv */
// Types, codes and per-channel update functions of the LED pattern engine.
package lbspe_pkg;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_LEVEL  = 3'd1,
    KIND_BLINK  = 3'd2,
    KIND_STROBE = 3'd3,
    KIND_STOP   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_BLINK  = 2'd1,
    MODE_STROBE = 2'd2
  } mode_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;
  localparam logic [7:0] ON_DEFAULT = 8'd255;

  typedef struct packed {
    logic [7:0]  level;
    logic [1:0]  mode;
    logic [15:0] rem;
    logic [15:0] phase;
    logic [15:0] pause;
    logic [7:0]  on;
    logic [7:0]  left;
    logic [7:0]  ppb;
    logic        is_on;
    logic        pausing;
  } chan_t;

  localparam int ChanBits = $bits(chan_t);

  localparam chan_t CHAN_RESET = '{
    level: 8'd0, mode: MODE_NONE, rem: 16'd0, phase: 16'd0, pause: 16'd0,
    on: ON_DEFAULT, left: 8'd0, ppb: 8'd0, is_on: 1'b0, pausing: 1'b0
  };

  typedef struct packed {
    logic       status;
    logic [2:0] chan;
    logic [7:0] level;
    logic       last;
  } res_t;

  function automatic logic [7:0] lit_drive(input chan_t s);
    return (s.on != 8'd0) ? s.on : ON_DEFAULT;
  endfunction

  function automatic chan_t halt(input chan_t s);
    chan_t r;
    r = s;
    r.mode    = MODE_NONE;
    r.pausing = 1'b0;
    r.is_on   = 1'b0;
    r.rem     = 16'd0;
    return r;
  endfunction

  // Advance one channel by one millisecond; fired reports a level applied.
  function automatic chan_t tick_chan(input chan_t s, output logic fired);
    chan_t r;
    r = s;
    fired = 1'b0;
    if (s.mode == MODE_NONE) begin
      r = s;
    end else if (s.rem > 16'd1) begin
      r.rem = s.rem - 16'd1;
    end else if (s.mode == MODE_BLINK) begin
      r.is_on = ~s.is_on;
      r.level = r.is_on ? lit_drive(s) : 8'd0;
      r.rem   = s.phase;
      fired   = 1'b1;
    end else if (s.pausing) begin
      r.pausing = 1'b0;
      r.left    = s.ppb;
      r.is_on   = 1'b0;
      r.rem     = s.phase;
    end else begin
      fired   = 1'b1;
      r.is_on = ~s.is_on;
      r.rem   = s.phase;
      if (r.is_on) begin
        r.level = lit_drive(s);
        if (s.left != 8'd0) r.left = s.left - 8'd1;
      end else begin
        r.level = 8'd0;
        if (s.left == 8'd0) begin
          if (s.pause == 16'd0) begin
            r = halt(r);
          end else begin
            r.pausing = 1'b1;
            r.rem     = s.pause;
          end
        end
      end
    end
    return r;
  endfunction

  // Apply a valid command to one channel; quot is burst_time / pulse_count.
  function automatic chan_t apply_cmd(input chan_t s, input logic [2:0] kind,
                                      input logic [7:0] lv, input logic [15:0] period,
                                      input logic [7:0] count, input logic [15:0] pause,
                                      input logic [15:0] quot);
    chan_t r;
    logic [15:0] p;
    logic [15:0] half;
    r = halt(s);
    p = 16'd0;
    half = 16'd0;
    if (kind == KIND_LEVEL) begin
      r.level = lv;
    end else if (kind == KIND_BLINK || kind == KIND_STROBE) begin
      if (s.level != 8'd0) r.on = s.level;
      r.level = 8'd0;
      if (kind == KIND_BLINK) begin
        half   = period >> 1;
        r.mode = MODE_BLINK;
      end else begin
        p      = (quot != 16'd0) ? quot : 16'd1;
        half   = p >> 1;
        r.mode = MODE_STROBE;
        r.pause = pause;
        r.left  = count;
        r.ppb   = count;
      end
      r.phase = (half != 16'd0) ? half : 16'd1;
      r.rem   = r.phase;
    end
    return r;
  endfunction

endpackage

/* hdl/led_blink_strobe_pattern_engine_core.sv */
// Top level of the LED level, blink and strobe pattern engine.
//
//   channel  valid        stall        payload
//   input    in_valid_i   in_stall_o   kind, channel, level, blink_period, pulse_count,
//                                      burst_time, pause_time
//   output   out_valid_o  out_stall_i  status, out_channel, out_level, duty, last
//
// A tick reads and rewrites the state of each channel in turn in the channel state memory
// (S_TRD, then S_TEX), and S_TFIN places the pending last result, if any. Set level and
// stop read the channel (S_CRD) and write it back (S_CEX); start strobe also waits in S_CEX
// for the bit-serial divider of burst time by pulse count. An invalid command goes through
// S_ERR. A stalled output holds the engine when it has a new result to place. After reset
// every channel reads as its reset state through per-channel valid bits; no clearing pass runs.
module led_blink_strobe_pattern_engine_core #(
  parameter int CHANNELS  = 6,
  parameter int DUTY_BITS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [2:0]  channel_i,
  input  logic [7:0]  level_i,
  input  logic [15:0] blink_period_i,
  input  logic [7:0]  pulse_count_i,
  input  logic [15:0] burst_time_i,
  input  logic [15:0] pause_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [2:0]  out_channel_o,
  output logic [7:0]  out_level_o,
  output logic [12:0] duty_o,
  output logic        last_o
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int XW = 8 + DUTY_BITS;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ERR  = 7'b0000010,
    S_CRD  = 7'b0000100,
    S_CEX  = 7'b0001000,
    S_TRD  = 7'b0010000,
    S_TEX  = 7'b0100000,
    S_TFIN = 7'b1000000
  } state_e;

  function automatic logic [12:0] duty_of(input logic [7:0] lv);
    logic [XW-1:0] x;
    logic [XW-1:0] est;
    logic [XW-1:0] r;
    x   = (XW'(lv) << DUTY_BITS) - XW'(lv);
    est = (x + (x >> 8)) >> 8;
    r   = x - ((est << 8) - est);
    for (int i = 0; i < 3; i++) begin
      if (r >= XW'(255)) begin
        r   = r - XW'(255);
        est = est + XW'(1);
      end
    end
    return est[12:0];
  endfunction

  state_e state_q, state_d;
  logic [2:0]  kind_q;
  logic [2:0]  ch_q;
  logic [7:0]  lv_q;
  logic [15:0] per_q;
  logic [7:0]  cnt_q;
  logic [15:0] pause_q;
  logic [AW-1:0] scan_q, scan_d;
  logic [CHANNELS-1:0] vld_q, vld_d;
  logic rvld_q, rvld_d;
  lbspe_pkg::res_t out_q, out_d, pend_q, pend_d;
  logic out_v_q, out_v_d, pend_v_q, pend_v_d;

  logic accept, out_free, bad, div_done;
  logic [15:0] quot;
  logic re, we;
  logic [AW-1:0] raddr, waddr;
  logic [lbspe_pkg::ChanBits-1:0] rdata;
  lbspe_pkg::chan_t rec, rec_tick, rec_cmd, wrec;
  logic fired;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_v_q || !out_stall_i;

  assign bad = (kind_i > lbspe_pkg::KIND_STOP) || ({1'b0, channel_i} >= 4'(CHANNELS)) ||
               (kind_i == lbspe_pkg::KIND_BLINK && blink_period_i == 16'd0) ||
               (kind_i == lbspe_pkg::KIND_STROBE &&
                (pulse_count_i == 8'd0 || burst_time_i == 16'd0));

  lbspe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && kind_i == lbspe_pkg::KIND_STROBE && !bad),
    .dividend_i (burst_time_i),
    .divisor_i  (pulse_count_i),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  lbspe_ram #(.WIDTH(lbspe_pkg::ChanBits), .DEPTH(CHANNELS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wrec),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rec      = rvld_q ? lbspe_pkg::chan_t'(rdata) : lbspe_pkg::CHAN_RESET;
  assign rec_cmd  = lbspe_pkg::apply_cmd(rec, kind_q, lv_q, per_q, cnt_q, pause_q, quot);

  always_comb begin
    rec_tick = lbspe_pkg::tick_chan(rec, fired);
  end

  always_comb begin
    state_d  = state_q;
    scan_d   = scan_q;
    vld_d    = vld_q;
    rvld_d   = rvld_q;
    out_d    = out_q;
    out_v_d  = out_v_q && out_stall_i;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    re       = 1'b0;
    we       = 1'b0;
    raddr    = AW'(ch_q);
    waddr    = AW'(ch_q);
    wrec     = rec_cmd;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          scan_d = '0;
          if (kind_i == lbspe_pkg::KIND_TICK) state_d = S_TRD;
          else if (bad) state_d = S_ERR;
          else state_d = S_CRD;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_d   = '{status: lbspe_pkg::STATUS_ERR, chan: ch_q, level: 8'd0, last: 1'b1};
          out_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CRD: begin
        re      = 1'b1;
        rvld_d  = vld_q[ch_q[AW-1:0]];
        state_d = S_CEX;
      end
      S_CEX: begin
        if (div_done && out_free) begin
          we      = 1'b1;
          vld_d[ch_q[AW-1:0]] = 1'b1;
          out_d   = '{status: lbspe_pkg::STATUS_OK, chan: ch_q, level: rec_cmd.level,
                      last: 1'b1};
          out_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TRD: begin
        re      = 1'b1;
        raddr   = scan_q;
        rvld_d  = vld_q[scan_q];
        state_d = S_TEX;
      end
      S_TEX: begin
        waddr = scan_q;
        wrec  = rec_tick;
        if (!(fired && pend_v_q && !out_free)) begin
          we = 1'b1;
          vld_d[scan_q] = 1'b1;
          if (fired) begin
            if (pend_v_q) begin
              out_d   = pend_q;
              out_v_d = 1'b1;
            end
            pend_d   = '{status: lbspe_pkg::STATUS_OK, chan: 3'(scan_q),
                         level: rec_tick.level, last: 1'b0};
            pend_v_d = 1'b1;
          end
          if (scan_q == AW'(CHANNELS - 1)) begin
            state_d = S_TFIN;
          end else begin
            scan_d  = scan_q + AW'(1);
            state_d = S_TRD;
          end
        end
      end
      S_TFIN: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vld_q    <= '0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      vld_q    <= vld_d;
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    rvld_q <= rvld_d;
    out_q  <= out_d;
    pend_q <= pend_d;
    if (accept) begin
      kind_q  <= kind_i;
      ch_q    <= channel_i;
      lv_q    <= level_i;
      per_q   <= blink_period_i;
      cnt_q   <= pulse_count_i;
      pause_q <= pause_time_i;
    end
  end

  assign out_valid_o   = out_v_q;
  assign status_o      = out_q.status;
  assign out_channel_o = out_q.chan;
  assign out_level_o   = out_q.level;
  assign duty_o        = duty_of(out_q.level);
  assign last_o        = out_q.last;

endmodule

/* hdl/lbspe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lbspe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/lbspe_div.sv */
// Restoring divider, 16-bit dividend by 8-bit divisor, one bit per cycle.
module lbspe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [7:0]  divisor_i,
  output logic        done_o,
  output logic [15:0] quot_o
);

  logic [15:0] q_q, q_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [8:0]  trial;

  always_comb begin
    q_d   = q_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    trial = {rem_q, q_q[15]};
    if (start_i) begin
      q_d   = dividend_i;
      rem_d = 8'd0;
      dvs_d = divisor_i;
      cnt_d = 5'd16;
    end else if (cnt_q != 5'd0) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 8'(trial - {1'b0, dvs_q});
        q_d   = {q_q[14:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        q_d   = {q_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = (cnt_q == 5'd0);
  assign quot_o = q_q;

endmodule

/* hdl/lbspe_chk.sv */
// Port-level assertions for the LED pattern engine, bound to the top level.
module lbspe_chk #(
  parameter int CHANNELS = 6
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        status_o,
  input logic [2:0]  out_channel_o,
  input logic [7:0]  out_level_o,
  input logic [12:0] duty_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_level_o))
    else $error("stalled result changed");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> out_level_o == 8'd0 && duty_o == 13'd0 && last_o)
    else $error("error result malformed");

  a_dark_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_level_o == 8'd0 |-> duty_o == 13'd0)
    else $error("nonzero duty at level zero");

  a_ok_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> {1'b0, out_channel_o} < 4'(CHANNELS))
    else $error("result on nonexistent channel");

endmodule

bind led_blink_strobe_pattern_engine_core lbspe_chk #(.CHANNELS(CHANNELS)) u_lbspe_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .out_channel_o (out_channel_o),
  .out_level_o   (out_level_o),
  .duty_o        (duty_o),
  .last_o        (last_o)
);

/* tb/tb_led_blink_strobe_pattern_engine_core.sv */
// Testbench of the LED level, blink and strobe pattern engine: directed table and random items.
`timescale 1ns / 100ps

module tb_led_blink_strobe_pattern_engine_core;

  localparam int NCH = 6;
  localparam int DMAX = (1 << 13) - 1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  chan;
    logic [7:0]  level;
    logic [15:0] period;
    logic [7:0]  count;
    logic [15:0] total;
    logic [15:0] pause;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic [2:0] chan;
    logic [7:0] level;
    logic [12:0] duty;
    logic       last;
  } led_res_t;

  typedef struct packed {
    cmd_t     cmd;
    logic     fixed;
    led_res_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] kind_i = '0;
  logic [2:0] channel_i = '0;
  logic [7:0] level_i = '0;
  logic [15:0] blink_period_i = '0;
  logic [7:0] pulse_count_i = '0;
  logic [15:0] burst_time_i = '0;
  logic [15:0] pause_time_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic status_o;
  logic [2:0] out_channel_o;
  logic [7:0] out_level_o;
  logic [12:0] duty_o;
  logic last_o;

  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  led_res_t led_results_due[$];
  logic [7:0]  m_level [NCH];
  logic [1:0]  m_mode [NCH];
  logic [15:0] m_rem [NCH];
  logic [15:0] m_phase [NCH];
  logic [15:0] m_pause [NCH];
  logic [7:0]  m_on [NCH];
  logic [7:0]  m_left [NCH];
  logic [7:0]  m_ppb [NCH];
  logic        m_is_on [NCH];
  logic        m_pausing [NCH];

  led_blink_strobe_pattern_engine_core u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("led_blink_strobe_pattern_engine_core test failed");
    $finish;
  end

  function automatic led_res_t make_res(logic st, logic [2:0] ch, logic [7:0] lv, logic lst);
    led_res_t r;
    r.status = st;
    r.chan = ch;
    r.level = lv;
    r.duty = 13'((32'(lv) * DMAX) / 255);
    r.last = lst;
    return r;
  endfunction

  function automatic logic [7:0] lit_level(int c);
    return (m_on[c] != 0) ? m_on[c] : 8'd255;
  endfunction

  function automatic void stop_chan(int c);
    m_mode[c] = lbspe_pkg::MODE_NONE;
    m_pausing[c] = 1'b0;
    m_is_on[c] = 1'b0;
    m_rem[c] = '0;
  endfunction

  function automatic bit step_pattern(int c);
    if (m_mode[c] == lbspe_pkg::MODE_BLINK) begin
      m_is_on[c] = !m_is_on[c];
      m_level[c] = m_is_on[c] ? lit_level(c) : 8'd0;
      m_rem[c] = m_phase[c];
      return 1;
    end
    if (m_pausing[c]) begin
      m_pausing[c] = 1'b0;
      m_left[c] = m_ppb[c];
      m_is_on[c] = 1'b0;
      m_rem[c] = m_phase[c];
      return 0;
    end
    m_is_on[c] = !m_is_on[c];
    if (m_is_on[c]) begin
      m_level[c] = lit_level(c);
      if (m_left[c] != 0) m_left[c]--;
    end else begin
      m_level[c] = 0;
      if (m_left[c] == 0) begin
        if (m_pause[c] == 0) begin
          stop_chan(c);
        end else begin
          m_pausing[c] = 1'b1;
          m_rem[c] = m_pause[c];
        end
        return 1;
      end
    end
    m_rem[c] = m_phase[c];
    return 1;
  endfunction

  function automatic void predict_led(cmd_t x, inout led_res_t q[$]);
    int n;
    int p;
    int h;
    n = q.size();
    if (x.kind == lbspe_pkg::KIND_TICK) begin
      for (int c = 0; c < NCH; c++) begin
        if (m_mode[c] == lbspe_pkg::MODE_NONE) continue;
        if (m_rem[c] > 1) begin
          m_rem[c]--;
          continue;
        end
        if (step_pattern(c))
          q.push_back(make_res(lbspe_pkg::STATUS_OK, 3'(c), m_level[c], 1'b0));
      end
      if (q.size() > n) q[q.size() - 1].last = 1'b1;
      return;
    end
    if (x.kind > lbspe_pkg::KIND_STOP || x.chan >= NCH ||
        (x.kind == lbspe_pkg::KIND_BLINK && x.period == 0) ||
        (x.kind == lbspe_pkg::KIND_STROBE && (x.count == 0 || x.total == 0))) begin
      q.push_back(make_res(lbspe_pkg::STATUS_ERR, x.chan, 8'd0, 1'b1));
      return;
    end
    stop_chan(x.chan);
    if (x.kind == lbspe_pkg::KIND_LEVEL) begin
      m_level[x.chan] = x.level;
    end else if (x.kind == lbspe_pkg::KIND_BLINK || x.kind == lbspe_pkg::KIND_STROBE) begin
      if (m_level[x.chan] != 0) m_on[x.chan] = m_level[x.chan];
      m_level[x.chan] = 0;
      if (x.kind == lbspe_pkg::KIND_BLINK) begin
        h = x.period / 2;
        m_mode[x.chan] = lbspe_pkg::MODE_BLINK;
      end else begin
        p = x.total / x.count;
        if (p == 0) p = 1;
        h = p / 2;
        m_mode[x.chan] = lbspe_pkg::MODE_STROBE;
        m_pause[x.chan] = x.pause;
        m_left[x.chan] = x.count;
        m_ppb[x.chan] = x.count;
      end
      m_phase[x.chan] = 16'((h != 0) ? h : 1);
      m_rem[x.chan] = m_phase[x.chan];
    end
    q.push_back(make_res(lbspe_pkg::STATUS_OK, x.chan, m_level[x.chan], 1'b1));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    led_res_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (led_results_due.size() == 0) begin
        report_mismatch("unexpected item", out_channel_o, -1);
      end else begin
        w = led_results_due.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (out_channel_o !== w.chan) report_mismatch("out_channel", out_channel_o, w.chan);
        if (out_level_o !== w.level) report_mismatch("out_level", out_level_o, w.level);
        if (duty_o !== w.duty) report_mismatch("duty", duty_o, w.duty);
        if (last_o !== w.last) report_mismatch("last", last_o, w.last);
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle);
  end

  task automatic send_cmd(cmd_t x, bit fixed, led_res_t want);
    led_res_t tmp[$];
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    predict_led(x, tmp);
    if (fixed && (tmp.size() != 1 || tmp[0] != want)) report_mismatch("table row", x.kind, x.chan);
    foreach (tmp[i]) led_results_due.push_back(tmp[i]);
    in_valid_i <= 1'b1;
    kind_i <= x.kind;
    channel_i <= x.chan;
    level_i <= x.level;
    blink_period_i <= x.period;
    pulse_count_i <= x.count;
    burst_time_i <= x.total;
    pause_time_i <= x.pause;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (led_results_due.size() != 0);
  endtask

  function automatic cmd_t mk(logic [2:0] k, logic [2:0] c, logic [7:0] l, logic [15:0] per,
                              logic [7:0] cnt, logic [15:0] tot, logic [15:0] pau);
    cmd_t x;
    x = '{k, c, l, per, cnt, tot, pau};
    return x;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t x;
    int r;
    x = cmd_t'({$urandom, $urandom, $urandom});
    r = $urandom_range(99);
    if (r < 45) begin
      x.kind = lbspe_pkg::KIND_TICK;
    end else if (r < 90) begin
      x.kind = 3'($urandom_range(1, 4));
      x.chan = 3'($urandom_range(NCH - 1));
      x.period = ($urandom_range(3) == 0) ? x.period : 16'($urandom_range(1, 12));
      if ($urandom_range(3) != 0) begin
        x.count = 8'($urandom_range(1, 4));
        x.total = 16'($urandom_range(1, 20));
        x.pause = 16'($urandom_range(0, 10));
      end
    end
    return x;
  endfunction

  row_t dir[$];

  initial begin
    for (int c = 0; c < NCH; c++) begin
      m_level[c] = 0; m_mode[c] = lbspe_pkg::MODE_NONE; m_rem[c] = 0; m_phase[c] = 0;
      m_pause[c] = 0; m_on[c] = 8'd255; m_left[c] = 0; m_ppb[c] = 0; m_is_on[c] = 0;
      m_pausing[c] = 0;
    end
    dir = '{
      '{mk(lbspe_pkg::KIND_TICK, 3'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(lbspe_pkg::KIND_STOP, 3'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0), 1'b1,
        make_res(lbspe_pkg::STATUS_OK, 3'd0, 8'd0, 1'b1)},
      '{mk(lbspe_pkg::KIND_LEVEL, 3'd1, 8'd255, 16'd0, 8'd0, 16'd0, 16'd0), 1'b1,
        make_res(lbspe_pkg::STATUS_OK, 3'd1, 8'd255, 1'b1)},
      '{mk(lbspe_pkg::KIND_LEVEL, 3'd6, 8'd9, 16'd0, 8'd0, 16'd0, 16'd0), 1'b1,
        make_res(lbspe_pkg::STATUS_ERR, 3'd6, 8'd0, 1'b1)},
      '{mk(lbspe_pkg::KIND_LEVEL, 3'd7, 8'd9, 16'd0, 8'd0, 16'd0, 16'd0), 1'b1,
        make_res(lbspe_pkg::STATUS_ERR, 3'd7, 8'd0, 1'b1)},
      '{mk(lbspe_pkg::KIND_BLINK, 3'd2, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0), 1'b1,
        make_res(lbspe_pkg::STATUS_ERR, 3'd2, 8'd0, 1'b1)},
      '{mk(lbspe_pkg::KIND_STROBE, 3'd2, 8'd0, 16'd0, 8'd0, 16'd5, 16'd0), 1'b1,
        make_res(lbspe_pkg::STATUS_ERR, 3'd2, 8'd0, 1'b1)},
      '{mk(lbspe_pkg::KIND_STROBE, 3'd2, 8'd0, 16'd0, 8'd3, 16'd0, 16'd0), 1'b1,
        make_res(lbspe_pkg::STATUS_ERR, 3'd2, 8'd0, 1'b1)},
      '{mk(3'd5, 3'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0), 1'b1,
        make_res(lbspe_pkg::STATUS_ERR, 3'd0, 8'd0, 1'b1)},
      '{mk(3'd7, 3'd5, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0), 1'b1,
        make_res(lbspe_pkg::STATUS_ERR, 3'd5, 8'd0, 1'b1)},
      '{mk(lbspe_pkg::KIND_LEVEL, 3'd5, 8'd128, 16'd0, 8'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(lbspe_pkg::KIND_BLINK, 3'd1, 8'd0, 16'd1, 8'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(lbspe_pkg::KIND_BLINK, 3'd0, 8'd0, 16'hFFFF, 8'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(lbspe_pkg::KIND_STROBE, 3'd2, 8'd0, 16'd0, 8'd2, 16'd8, 16'd0), 1'b0, '0},
      '{mk(lbspe_pkg::KIND_STROBE, 3'd3, 8'd0, 16'd0, 8'd255, 16'd1, 16'd3), 1'b0, '0},
      '{mk(lbspe_pkg::KIND_STROBE, 3'd4, 8'd0, 16'd0, 8'd1, 16'hFFFF, 16'hFFFF),
        1'b0, '0},
      '{mk(lbspe_pkg::KIND_TICK, 3'd7, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF),
        1'b0, '0},
      '{mk(lbspe_pkg::KIND_TICK, 3'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(lbspe_pkg::KIND_TICK, 3'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(lbspe_pkg::KIND_TICK, 3'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(lbspe_pkg::KIND_TICK, 3'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(lbspe_pkg::KIND_STOP, 3'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0), 1'b0, '0},
      '{mk(lbspe_pkg::KIND_STOP, 3'd4, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0), 1'b0, '0}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 24;
    recv_idle = 61;
    foreach (dir[i]) send_cmd(dir[i].cmd, dir[i].fixed, dir[i].res);
    for (int i = 0; i < 200; i++) begin
      if (i == 70) begin
        send_idle = 61;
        recv_idle = 24;
      end
      if (i == 140) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (i == 100) begin
        drain_results();
      end
      send_cmd(rand_cmd(), 1'b0, '0);
    end
    drain_results();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && led_results_due.size() == 0) begin
      $display("led_blink_strobe_pattern_engine_core test passed");
    end else begin
      $display("led_blink_strobe_pattern_engine_core test failed");
    end
    $finish;
  end

endmodule

/* led_blink_strobe_pattern_engine_core.f */
hdl/lbspe_pkg.sv
hdl/lbspe_ram.sv
hdl/lbspe_div.sv
hdl/led_blink_strobe_pattern_engine_core.sv
hdl/lbspe_chk.sv
tb/tb_led_blink_strobe_pattern_engine_core.sv
